FILE: hw/rtl/header_param_pair_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef HEADER_PARAM_PAIR_TOKENIZER_DEFINES_SVH
`define HEADER_PARAM_PAIR_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define HPPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HPPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/hppt_pkg.sv
package hppt_pkg;

    localparam int MAX_HEADER_BYTES = 4096;
    localparam int INDEX_WIDTH      = 8;

    localparam int OFF_W = 12;
    localparam int CNT_W = 8;
    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_HEADER_BYTES);
    localparam logic [CNT_W-1:0] IDX_LIMIT =
        (INDEX_WIDTH >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((1 << INDEX_WIDTH) - 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef enum logic [6:0] {
        ST_BEGIN_NAME  = 7'b0000001,
        ST_NAME        = 7'b0000010,
        ST_END_NAME    = 7'b0000100,
        ST_BEGIN_VALUE = 7'b0001000,
        ST_VALUE       = 7'b0010000,
        ST_QUOTED      = 7'b0100000,
        ST_END_VALUE   = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        logic             pair_done;
        logic [OFF_W-1:0] name_start;
        logic [OFF_W-1:0] name_len;
        logic [OFF_W-1:0] value_start;
        logic [OFF_W-1:0] value_len;
        logic [CNT_W-1:0] param_index;
        logic [CNT_W-1:0] pair_index;
        logic             parse_error;
        logic             header_end;
        logic             header_valid;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_value_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH) || (c == CH_UNDER);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < IDX_LIMIT) ? v + CNT_W'(1) : v;
    endfunction

endpackage

FILE: hw/rtl/hppt_parser.sv
`include "header_param_pair_tokenizer_defines.svh"

module hppt_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    output hppt_pkg::result_t result
);

    hppt_pkg::parse_state_t           state_reg, state_next;
    logic [hppt_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [hppt_pkg::OFF_W-1:0]       name_start_reg, name_start_next;
    logic [hppt_pkg::OFF_W-1:0]       name_len_reg, name_len_next;
    logic [hppt_pkg::OFF_W-1:0]       value_start_reg, value_start_next;
    logic [hppt_pkg::OFF_W-1:0]       value_len_reg, value_len_next;
    logic [hppt_pkg::CNT_W-1:0]       param_reg, param_next;
    logic [hppt_pkg::CNT_W-1:0]       pair_reg, pair_next;
    logic                             error_reg, error_next;

    logic                             pos_ok;
    logic [hppt_pkg::OFF_W-1:0]       p_off;
    logic                             done;
    logic                             c_blank, c_name, c_value;

    assign pos_ok  = pos_reg < hppt_pkg::POS_LIMIT;
    assign p_off   = hppt_pkg::OFF_W'(pos_reg);
    assign c_blank = hppt_pkg::is_blank(byte_in);
    assign c_name  = hppt_pkg::is_name_char(byte_in);
    assign c_value = hppt_pkg::is_value_char(byte_in);

    always_comb begin
        state_next       = state_reg;
        name_start_next  = name_start_reg;
        name_len_next    = name_len_reg;
        value_start_next = value_start_reg;
        value_len_next   = value_len_reg;
        param_next       = param_reg;
        pair_next        = pair_reg;
        error_next       = error_reg;
        done             = 1'b0;
        pos_next         = pos_ok ? pos_reg + hppt_pkg::POS_W'(1) : pos_reg;

        if (!pos_ok) begin
            error_next = 1'b1;
        end else if (!error_reg) begin
            unique case (state_reg)
                hppt_pkg::ST_BEGIN_NAME: begin
                    if (c_blank) begin
                    end else if (c_name) begin
                        // open a name; this byte is its first character
                        name_start_next  = p_off;
                        name_len_next    = hppt_pkg::OFF_W'(1);
                        value_start_next = '0;
                        value_len_next   = '0;
                        state_next       = hppt_pkg::ST_NAME;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_NAME: begin
                    if (c_name) begin
                        name_len_next = name_len_reg + hppt_pkg::OFF_W'(1);
                    end else if (c_blank) begin
                        state_next = hppt_pkg::ST_END_NAME;
                    end else if (byte_in == hppt_pkg::CH_EQ) begin
                        state_next = hppt_pkg::ST_BEGIN_VALUE;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_END_NAME: begin
                    if (c_blank) begin
                    end else if (byte_in == hppt_pkg::CH_EQ) begin
                        state_next = hppt_pkg::ST_BEGIN_VALUE;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_BEGIN_VALUE: begin
                    if (c_blank) begin
                    end else if (c_value) begin
                        value_start_next = p_off;
                        value_len_next   = value_len_reg + hppt_pkg::OFF_W'(1);
                        state_next       = hppt_pkg::ST_VALUE;
                    end else if (byte_in == hppt_pkg::CH_QUOTE) begin
                        value_start_next = p_off + hppt_pkg::OFF_W'(1);
                        state_next       = hppt_pkg::ST_QUOTED;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_VALUE: begin
                    if (c_value) begin
                        value_len_next = value_len_reg + hppt_pkg::OFF_W'(1);
                    end else if (c_blank) begin
                        done       = 1'b1;
                        state_next = hppt_pkg::ST_END_VALUE;
                    end else if (byte_in == hppt_pkg::CH_SEMI) begin
                        done       = 1'b1;
                        pair_next  = hppt_pkg::sat_inc(pair_reg);
                        state_next = hppt_pkg::ST_BEGIN_NAME;
                    end else if (byte_in == hppt_pkg::CH_COMMA) begin
                        done       = 1'b1;
                        param_next = hppt_pkg::sat_inc(param_reg);
                        pair_next  = '0;
                        state_next = hppt_pkg::ST_BEGIN_NAME;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_QUOTED: begin
                    if (byte_in == hppt_pkg::CH_QUOTE) begin
                        done       = 1'b1;
                        state_next = hppt_pkg::ST_END_VALUE;
                    end else if (c_value) begin
                        value_len_next = value_len_reg + hppt_pkg::OFF_W'(1);
                    end else begin
                        error_next = 1'b1;
                    end
                end
                hppt_pkg::ST_END_VALUE: begin
                    if (c_blank) begin
                    end else if (byte_in == hppt_pkg::CH_SEMI) begin
                        pair_next  = hppt_pkg::sat_inc(pair_reg);
                        state_next = hppt_pkg::ST_BEGIN_NAME;
                    end else if (byte_in == hppt_pkg::CH_COMMA) begin
                        param_next = hppt_pkg::sat_inc(param_reg);
                        pair_next  = '0;
                        state_next = hppt_pkg::ST_BEGIN_NAME;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                default: begin
                    error_next = 1'b1;
                end
            endcase
        end

        // close a trailing bare value at the last byte
        if (last_in && !error_next && state_next == hppt_pkg::ST_VALUE) begin
            done       = 1'b1;
            state_next = hppt_pkg::ST_END_VALUE;
        end

        result.pair_done    = done;
        result.name_start   = done ? name_start_next : '0;
        result.name_len     = done ? name_len_next : '0;
        result.value_start  = done ? value_start_next : '0;
        result.value_len    = done ? value_len_next : '0;
        result.param_index  = done ? param_reg : '0;
        result.pair_index   = done ? pair_reg : '0;
        result.parse_error  = error_next;
        result.header_end   = last_in;
        result.header_valid = last_in && !error_next &&
                              (state_next == hppt_pkg::ST_END_VALUE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_in)) begin
            state_reg       <= hppt_pkg::ST_BEGIN_NAME;
            pos_reg         <= '0;
            name_start_reg  <= '0;
            name_len_reg    <= '0;
            value_start_reg <= '0;
            value_len_reg   <= '0;
            param_reg       <= '0;
            pair_reg        <= '0;
            error_reg       <= 1'b0;
        end else if (step_en) begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            name_start_reg  <= name_start_next;
            name_len_reg    <= name_len_next;
            value_start_reg <= value_start_next;
            value_len_reg   <= value_len_next;
            param_reg       <= param_next;
            pair_reg        <= pair_next;
            error_reg       <= error_next;
        end
    end

    `HPPT_ASSERT_IMP(a_done_no_err, aclk, aresetn, result.pair_done, !result.parse_error, "pair reported together with an error")
    `HPPT_ASSERT_IMP(a_valid_at_end, aclk, aresetn, result.header_valid, result.header_end && !result.parse_error, "header_valid outside a clean header end")
    `HPPT_ASSERT_NXT(a_end_clears, aclk, aresetn, step_en && last_in, state_reg == hppt_pkg::ST_BEGIN_NAME && pos_reg == '0 && !error_reg, "state not cleared after the last byte")
    `HPPT_ASSERT_NXT(a_err_sticky, aclk, aresetn, step_en && !last_in && error_reg, error_reg, "error dropped before the header end")
    `HPPT_ASSERT_IMP(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= hppt_pkg::POS_LIMIT, "byte offset beyond its limit")

endmodule

FILE: hw/rtl/header_param_pair_tokenizer.sv
// Header parameter tokenizer. Feed one header byte per word on the s_
// channel, with s_last_byte high on the final byte; each accepted word
// yields exactly one result word on the m_ channel. A result carries
// m_pair_done when that byte (or, on the last byte, the implied end of a
// bare value) finishes a name=value pair, together with the name and value
// offsets and lengths (12-bit, wrapping) and the saturating parameter and
// pair indexes; otherwise those fields are zero. m_parse_error is sticky
// for the rest of the header, and on the last byte m_header_end is high and
// m_header_valid tells whether the header parsed completely and cleanly.
// After the last byte the parser returns to its reset state. Throughput is
// one byte per clock while m_ready stays high: the whole parse step for a
// byte is combinational logic between the input register and the result
// register. An accepted word passes through the input register and then
// the result register, which drives m_valid. Backpressure on m_ready holds
// the result register and, once the input register also fills, drops
// s_ready.
module header_param_pair_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pair_done,
    output logic [11:0] m_name_start,
    output logic [11:0] m_name_len,
    output logic [11:0] m_value_start,
    output logic [11:0] m_value_len,
    output logic [7:0]  m_param_index,
    output logic [7:0]  m_pair_index,
    output logic        m_parse_error,
    output logic        m_header_end,
    output logic        m_header_valid
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    hppt_pkg::result_t out_reg;
    hppt_pkg::result_t step_result;

    logic              advance;
    logic              s_fire;

    // Advance the held byte through the parser whenever the result
    // register is empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payloads until the next word moves in.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_last_byte;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    hppt_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .result  (step_result)
    );

    assign m_valid        = out_valid_reg;
    assign m_pair_done    = out_reg.pair_done;
    assign m_name_start   = out_reg.name_start;
    assign m_name_len     = out_reg.name_len;
    assign m_value_start  = out_reg.value_start;
    assign m_value_len    = out_reg.value_len;
    assign m_param_index  = out_reg.param_index;
    assign m_pair_index   = out_reg.pair_index;
    assign m_parse_error  = out_reg.parse_error;
    assign m_header_end   = out_reg.header_end;
    assign m_header_valid = out_reg.header_valid;

endmodule

FILE: tb/tb_header_param_pair_tokenizer.sv
module tb_header_param_pair_tokenizer;
    import hppt_pkg::*;

    localparam int CLK_PERIOD = 12;

    // One byte of header text as queued for the sender. Setting drain makes
    // the sender wait until every outstanding result word has come back.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } hdr_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pair_done;
    logic [11:0] m_name_start;
    logic [11:0] m_name_len;
    logic [11:0] m_value_start;
    logic [11:0] m_value_len;
    logic [7:0]  m_param_index;
    logic [7:0]  m_pair_index;
    logic        m_parse_error;
    logic        m_header_end;
    logic        m_header_valid;

    header_param_pair_tokenizer uut (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Stimulus and scoreboard storage.
    hdr_word_t  bytes_to_send[$];
    result_t    results_due[$];
    logic [7:0] hdr_build[$];

    int words_total = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int mismatches = 0;
    int headers_seen = 0;
    int headers_clean = 0;
    int headers_flagged = 0;
    int pairs_seen = 0;
    bit word_taken = 1'b0;
    int send_gap = 0;
    int send_quiet = 0;
    int stall_left = 0;
    int stall_quiet = 0;

    // ------------------------------------------------------------------
    // Tokenizer state as the checker tracks it
    // ------------------------------------------------------------------
    parse_state_t tok_state = ST_BEGIN_NAME;
    int unsigned  tok_pos = 0;
    int unsigned  tok_name_start = 0;
    int unsigned  tok_name_len = 0;
    int unsigned  tok_val_start = 0;
    int unsigned  tok_val_len = 0;
    logic [7:0]   tok_param_idx = '0;
    logic [7:0]   tok_pair_idx = '0;
    bit           tok_error = 1'b0;

    function automatic bit is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic bit is_token_ch(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic bit is_b64url_ch(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH) || (c == CH_UNDER);
    endfunction

    // Saturating index count: stop at the top of the index range.
    function automatic logic [7:0] bump_index(input logic [7:0] v);
        return (v < IDX_LIMIT) ? v + 8'd1 : v;
    endfunction

    // Return every tracked field to its power-up value: start a new header.
    function automatic void restart_header();
        tok_state = ST_BEGIN_NAME;
        tok_pos = 0;
        tok_name_start = 0;
        tok_name_len = 0;
        tok_val_start = 0;
        tok_val_len = 0;
        tok_param_idx = '0;
        tok_pair_idx = '0;
        tok_error = 1'b0;
    endfunction

    // Look at byte c at offset p once. Return 1 when the byte is used up,
    // 0 when a state change wants the same byte looked at again. Raise done
    // when a pair finishes; set the sticky error on anything out of place.
    function automatic bit scan_char(input logic [7:0] c, input int unsigned p,
                                     output bit done);
        done = 1'b0;
        case (tok_state)
            ST_BEGIN_NAME: begin
                if (is_ws(c)) return 1'b1;
                if (is_token_ch(c)) begin
                    tok_name_start = p;
                    tok_name_len = 0;
                    tok_val_start = 0;
                    tok_val_len = 0;
                    tok_state = ST_NAME;
                    return 1'b0;
                end
            end
            ST_NAME: begin
                if (is_token_ch(c)) begin
                    tok_name_len++;
                    return 1'b1;
                end
                if (is_ws(c) || c == CH_EQ) begin
                    tok_state = ST_END_NAME;
                    return 1'b0;
                end
            end
            ST_END_NAME: begin
                if (is_ws(c)) return 1'b1;
                if (c == CH_EQ) begin
                    tok_state = ST_BEGIN_VALUE;
                    return 1'b1;
                end
            end
            ST_BEGIN_VALUE: begin
                if (is_ws(c)) return 1'b1;
                if (is_b64url_ch(c)) begin
                    tok_val_start = p;
                    tok_state = ST_VALUE;
                    return 1'b0;
                end
                if (c == CH_QUOTE) begin
                    // the value begins after the opening quote
                    tok_val_start = p + 1;
                    tok_state = ST_QUOTED;
                    return 1'b1;
                end
            end
            ST_VALUE: begin
                if (is_ws(c) || c == CH_SEMI || c == CH_COMMA) begin
                    tok_state = ST_END_VALUE;
                    done = 1'b1;
                    return 1'b0;
                end
                if (is_b64url_ch(c)) begin
                    tok_val_len++;
                    return 1'b1;
                end
            end
            ST_QUOTED: begin
                if (c == CH_QUOTE) begin
                    tok_state = ST_END_VALUE;
                    done = 1'b1;
                    return 1'b1;
                end
                if (is_b64url_ch(c)) begin
                    tok_val_len++;
                    return 1'b1;
                end
            end
            ST_END_VALUE: begin
                if (is_ws(c)) return 1'b1;
                if (c == CH_SEMI) begin
                    tok_pair_idx = bump_index(tok_pair_idx);
                    tok_state = ST_BEGIN_NAME;
                    return 1'b1;
                end
                if (c == CH_COMMA) begin
                    tok_param_idx = bump_index(tok_param_idx);
                    tok_pair_idx = '0;
                    tok_state = ST_BEGIN_NAME;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        tok_error = 1'b1;
        return 1'b1;
    endfunction

    // Push byte c through the parser until it is used up, and fill in the
    // pair fields of r when it finishes a pair.
    function automatic void feed_char(input logic [7:0] c, input int unsigned p,
                                      inout result_t r);
        bit done;
        bit used;
        int passes;
        used = 1'b0;
        passes = 0;
        while (!used && passes < 4 && !tok_error) begin
            used = scan_char(c, p, done);
            if (done) begin
                r.pair_done   = 1'b1;
                r.name_start  = tok_name_start[11:0];
                r.name_len    = tok_name_len[11:0];
                r.value_start = tok_val_start[11:0];
                r.value_len   = tok_val_len[11:0];
                r.param_index = tok_param_idx;
                r.pair_index  = tok_pair_idx;
            end
            passes++;
        end
    endfunction

    // Work out the result word that one accepted header byte produces.
    function automatic result_t tokenize_byte(input logic [7:0] c, input logic last);
        result_t r;
        r = '0;
        if (tok_pos >= MAX_HEADER_BYTES)
            tok_error = 1'b1;
        else if (!tok_error)
            feed_char(c, tok_pos, r);
        if (tok_pos < MAX_HEADER_BYTES)
            tok_pos++;
        r.parse_error = tok_error;
        if (last) begin
            // close a trailing bare value as if a blank followed it
            if (!tok_error && tok_state == ST_VALUE)
                feed_char(CH_SPACE, tok_pos, r);
            r.parse_error  = tok_error;
            r.header_end   = 1'b1;
            r.header_valid = !tok_error && (tok_state == ST_END_VALUE);
            restart_header();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic push_word(input logic [7:0] c, input logic last, input logic drain);
        hdr_word_t w;
        w.ch = c;
        w.last = last;
        w.drain = drain;
        bytes_to_send.push_back(w);
        words_total++;
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_word(txt[i], i == txt.len() - 1, 1'b0);
    endtask

    // Move the header under construction into the send queue, marking its
    // last byte; optionally make the sender drain first.
    task automatic flush_header(input bit drain_first);
        for (int i = 0; i < hdr_build.size(); i++)
            push_word(hdr_build[i], i == hdr_build.size() - 1, drain_first && i == 0);
        hdr_build.delete();
    endtask

    task automatic add_blanks();
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n) hdr_build.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
    endtask

    function automatic logic [7:0] pick_name_ch();
        int r;
        r = $urandom_range(0, 35);
        return (r < 26) ? 8'("a" + r) : 8'("0" + r - 26);
    endfunction

    function automatic logic [7:0] pick_value_ch();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return (r == 62) ? CH_DASH : CH_UNDER;
    endfunction

    // Mostly well-formed headers with random names, values and spacing;
    // a few are pure noise, and some get a byte corrupted or are cut short.
    task automatic add_random_header(input bit drain_first);
        int kind;
        int nparam;
        int npair;
        int n;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            n = $urandom_range(1, 12);
            repeat (n) hdr_build.push_back(8'($urandom_range(0, 255)));
        end else begin
            nparam = $urandom_range(1, 3);
            for (int i = 0; i < nparam; i++) begin
                if (i > 0) begin
                    add_blanks();
                    hdr_build.push_back(CH_COMMA);
                end
                npair = $urandom_range(1, 3);
                for (int j = 0; j < npair; j++) begin
                    if (j > 0) begin
                        add_blanks();
                        hdr_build.push_back(CH_SEMI);
                    end
                    add_blanks();
                    n = $urandom_range(1, 6);
                    repeat (n) hdr_build.push_back(pick_name_ch());
                    add_blanks();
                    hdr_build.push_back(CH_EQ);
                    add_blanks();
                    if ($urandom_range(0, 9) < 3) begin
                        hdr_build.push_back(CH_QUOTE);
                        n = $urandom_range(0, 8);
                        repeat (n) hdr_build.push_back(pick_value_ch());
                        hdr_build.push_back(CH_QUOTE);
                    end else begin
                        n = $urandom_range(1, 8);
                        repeat (n) hdr_build.push_back(pick_value_ch());
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) add_blanks();
            if (kind >= 84) begin
                cut = $urandom_range(0, hdr_build.size() - 1);
                if (kind < 92)
                    hdr_build[cut] = 8'($urandom_range(0, 255));
                else
                    while (hdr_build.size() > cut + 1) void'(hdr_build.pop_back());
            end
        end
        flush_header(drain_first);
    endtask

    // One long header: push the pair index and then the parameter index
    // into saturation, then run past the maximum header length.
    task automatic add_long_header();
        repeat (300) begin
            hdr_build.push_back("a");
            hdr_build.push_back(CH_EQ);
            hdr_build.push_back("b");
            hdr_build.push_back(CH_SEMI);
        end
        repeat (300) begin
            hdr_build.push_back("c");
            hdr_build.push_back(CH_EQ);
            hdr_build.push_back("d");
            hdr_build.push_back(CH_COMMA);
        end
        while (hdr_build.size() < MAX_HEADER_BYTES + 4) begin
            hdr_build.push_back(CH_SPACE);
            hdr_build.push_back("e");
            hdr_build.push_back(CH_EQ);
            hdr_build.push_back("f");
        end
        flush_header(1'b1);
    endtask

    // Idle length for either side: mostly none or short, a few long, and
    // now and then a quiet stretch with no idling at all.
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0) begin
            quiet = $urandom_range(40, 120);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Sender: change inputs on the falling edge. Hold a presented word
    // until the rising edge that takes it, then idle or advance.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_bytes
        hdr_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !word_taken) begin
            // hold: payload stays put until accepted
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            s_valid <= 1'b0;
        end else if (bytes_to_send.size() == 0 ||
                     (bytes_to_send[0].drain && results_due.size() != 0)) begin
            // nothing left, or wait for every outstanding result to return
            s_valid <= 1'b0;
        end else begin
            w = bytes_to_send.pop_front();
            s_valid <= 1'b1;
            s_byte_value <= w.ch;
            s_last_byte <= w.last;
            send_gap = pick_idle(send_quiet);
        end
    end

    // Receiver: stall m_ready at random, also on the falling edge.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_idle(stall_quiet);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Predict on each
    // accepted input word first, then check any accepted result word
    // against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("result word %0d: %s expected %0d, got %0d",
                     results_checked, what, want, got);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) flag_mismatch(what, want, got);
    endtask

    always @(posedge aclk) begin : watch_ports
        result_t got;
        result_t want;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                results_due.push_back(tokenize_byte(s_byte_value, s_last_byte));
                words_accepted++;
                word_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                got = {m_pair_done, m_name_start, m_name_len, m_value_start,
                       m_value_len, m_param_index, m_pair_index, m_parse_error,
                       m_header_end, m_header_valid};
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected word, outstanding count", 0, 1);
                end else begin
                    want = results_due.pop_front();
                    check_field("pair_done", want.pair_done, got.pair_done);
                    check_field("name_start", want.name_start, got.name_start);
                    check_field("name_len", want.name_len, got.name_len);
                    check_field("value_start", want.value_start, got.value_start);
                    check_field("value_len", want.value_len, got.value_len);
                    check_field("param_index", want.param_index, got.param_index);
                    check_field("pair_index", want.pair_index, got.pair_index);
                    check_field("parse_error", want.parse_error, got.parse_error);
                    check_field("header_end", want.header_end, got.header_end);
                    check_field("header_valid", want.header_valid, got.header_valid);
                end
                results_checked++;
                if (got.pair_done) pairs_seen++;
                if (got.header_end) begin
                    headers_seen++;
                    if (got.header_valid) headers_clean++;
                    if (got.parse_error) headers_flagged++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int random_from;

        // Directed headers: a bare value closed by the last byte; tab,
        // blanks, a quoted value, a new parameter and a one-digit value;
        // an empty quoted value followed by ';' so the header ends
        // incomplete; and a header of the byte extremes, which is invalid.
        push_text("a=b");
        push_text("k1\t= \"Z-_\" ,p=9");
        push_text("x=\"\";");
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hff, 1'b1, 1'b0);

        // Index saturation and the overlong header, after a full drain.
        add_long_header();

        // Random headers; drain the pipe before a few of them.
        random_from = words_total;
        while (words_total - random_from < 550)
            add_random_header($urandom_range(0, 11) == 0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (words_accepted < words_total || results_due.size() != 0)
            @(posedge aclk);
        // let a stray late result show up before closing
        repeat (8) @(posedge aclk);

        $display("Checked %0d result words over %0d headers: %0d pairs reported,",
                 results_checked, headers_seen, pairs_seen);
        $display("%0d headers clean, %0d with the error flag, index saturation and overlong input included",
                 headers_clean, headers_flagged);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: stop a hung run well past the slowest legal finish.
    initial begin : watchdog
        #(CLK_PERIOD * 1200000);
        $display("Mismatches found");
        $finish;
    end

endmodule
